/* hdl/bhpq_pkg.sv */
// ----------------------------------------------------------------------------
// bhpq_pkg: shared types and constants for the binary heap priority queue
// Operation, status, register index and controller state codes, widths and
// the command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package bhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int AW = $clog2(CAPACITY + 1);
	localparam int CW = 11;
	localparam int VW = 32;
	localparam int TW = 32;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_EXTRACT = 3'd1,
		OP_PEEK    = 3'd2,
		OP_RAISE   = 3'd3,
		OP_LOWER   = 3'd4,
		OP_DELETE  = 3'd5
	} op_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_BAD_POS  = 3'd3;
	localparam logic [2:0] ST_WRONG_DIR = 3'd4;

	localparam logic [0:0] REG_ORDER = 1'd0;
	localparam logic [0:0] REG_LIMIT = 1'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_POS,
		S_CHECK,
		S_RD_LAST,
		S_PLACE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD_L,
		S_DN_RD_R,
		S_DN_CMP,
		S_TOP_RD,
		S_TOP_CAP,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_LOAD,
		C_RD_POS,
		C_CHECK,
		C_RD_LAST,
		C_PLACE,
		C_UP_RD,
		C_UP_CMP,
		C_DN_RD_L,
		C_DN_RD_R,
		C_DN_CMP,
		C_TOP_RD,
		C_TOP_CAP,
		C_EMIT
	} cmd_t;

	typedef struct packed {
		logic       done_early;
		logic       go_up;
		logic       go_down;
		logic       go_top;
		logic       need_last;
		logic       retry_down;
		logic       up_more;
		logic       dn_more;
		logic       has_right;
		logic       out_busy;
	} stat_t;

	function automatic logic beats(input logic mn, input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b);
		beats = mn ? (a < b) : (a > b);
	endfunction

endpackage

/* hdl/bhpq_if.sv */
// ----------------------------------------------------------------------------
// bhpq_if: valid/ready channel interfaces
// Request, result and register write channels.
// ----------------------------------------------------------------------------
interface bhpq_req_if import bhpq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [2:0]           operation;
	logic [CW-1:0]        position;
	logic signed [VW-1:0] new_value;
	modport source (output valid, operation, position, new_value, input ready);
	modport sink (input valid, operation, position, new_value, output ready);
endinterface

interface bhpq_rsp_if import bhpq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [VW-1:0] result_value;
	logic [TW-1:0]        result_tag;
	logic [2:0]           status;
	logic [CW-1:0]        entry_count;
	modport source (output valid, result_value, result_tag, status, entry_count,
		input ready);
	modport sink (input valid, result_value, result_tag, status, entry_count,
		output ready);
endinterface

interface bhpq_cfg_if import bhpq_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [0:0]    index;
	logic [CW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/binary_heap_priority_queue.sv */
// Latency from acceptance to result valid grows with the levels an operation sifts up or down,
// since each sift step reads and writes through the single RAM port; a refused or unknown
// operation or a peek does no sift.
// Throughput: one operation at a time; the next is accepted the cycle after the result is registered.
// Reset: asynchronous, clears size, tag counter and order register, sets the limit to 1024; no clearing pass.
// ----------------------------------------------------------------------------
// binary_heap_priority_queue: max/min binary heap with insertion tags
// Controller sequences sifts over a single-port entry memory in the datapath.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue import bhpq_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	bhpq_req_if.sink    req,
	bhpq_rsp_if.source  rsp,
	bhpq_cfg_if.sink    cfg
);
	cmd_t  cmd;
	stat_t stat;

	assign cfg.ready = 1'b1;

	bhpq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
		.stat(stat), .cmd(cmd)
	);

	bhpq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_op(req.operation), .in_pos(req.position), .in_val(req.new_value),
		.cfg_we(cfg.valid), .cfg_idx(cfg.index), .cfg_data(cfg.data),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_value(rsp.result_value),
		.rsp_tag(rsp.result_tag), .rsp_status(rsp.status), .rsp_count(rsp.entry_count)
	);
endmodule

/* hdl/bhpq_ram.sv */
// ----------------------------------------------------------------------------
// bhpq_ram: generic single-port RAM
// One access per cycle: a read, or a write that also returns the old contents; registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* hdl/bhpq_datapath.sv */
// ----------------------------------------------------------------------------
// bhpq_datapath: heap storage, index registers and result register
// Executes one controller command per cycle against the entry memory.
// ----------------------------------------------------------------------------
module bhpq_datapath import bhpq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic [2:0]           in_op,
	input  logic [CW-1:0]        in_pos,
	input  logic signed [VW-1:0] in_val,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_idx,
	input  logic [CW-1:0]        cfg_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic signed [VW-1:0] rsp_value,
	output logic [TW-1:0]        rsp_tag,
	output logic [2:0]           rsp_status,
	output logic [CW-1:0]        rsp_count
);
	localparam int EW = VW + TW;

	logic                 order_min_q;
	logic [CW-1:0]        limit_q;
	logic [AW-1:0]        occ_q;
	logic [TW-1:0]        ctr_q;
	logic [2:0]           op_q;
	logic [AW-1:0]        pos_q;
	logic signed [VW-1:0] nv_q;
	logic [AW-1:0]        i_q;
	logic [AW-1:0]        best_q;
	logic signed [VW-1:0] cur_v_q;
	logic [TW-1:0]        cur_t_q;
	logic signed [VW-1:0] oth_v_q;
	logic [TW-1:0]        oth_t_q;
	logic signed [VW-1:0] bv_q;
	logic [TW-1:0]        bt_q;
	logic signed [VW-1:0] res_v_q;
	logic [TW-1:0]        res_t_q;
	logic [2:0]           res_st_q;
	logic                 dir_up_q;
	logic                 out_v_q;
	logic signed [VW-1:0] out_val_q;
	logic [TW-1:0]        out_tag_q;
	logic [2:0]           out_st_q;
	logic [CW-1:0]        out_cnt_q;

	logic                 we;
	logic [AW-1:0]        addr;
	logic [EW-1:0]        wdata;
	logic [EW-1:0]        rdata;
	logic signed [VW-1:0] rd_v;
	logic [TW-1:0]        rd_t;
	logic [AW:0]          lim_eff;
	logic [AW-1:0]        left_i;
	logic [AW-1:0]        right_i;
	logic [AW-1:0]        parent_i;
	logic                 right_ok;
	logic [AW-1:0]        dn_best_i;
	logic signed [VW-1:0] dn_best_v;
	logic [TW-1:0]        dn_best_t;

	bhpq_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign rd_v = rdata[EW-1:TW];
	assign rd_t = rdata[TW-1:0];
	assign parent_i = i_q >> 1;
	assign left_i = {i_q[AW-2:0], 1'b0};
	assign right_i = {i_q[AW-2:0], 1'b1};
	assign right_ok = {1'b0, right_i} <= {1'b0, occ_q} && i_q < AW'(2 ** (AW - 1));
	assign lim_eff = ({1'b0, AW'(limit_q)} < (AW + 1)'(CAPACITY)) ?
		{1'b0, AW'(limit_q)} : (AW + 1)'(CAPACITY);

	always_comb begin
		dn_best_i = best_q;
		dn_best_v = bv_q;
		dn_best_t = bt_q;
		if (right_ok && beats(order_min_q, rd_v, bv_q)) begin
			dn_best_i = right_i;
			dn_best_v = rd_v;
			dn_best_t = rd_t;
		end
	end

	always_comb begin
		we = 1'b0;
		addr = i_q;
		wdata = {cur_v_q, cur_t_q};
		unique case (cmd)
			C_RD_POS: addr = (op_q == OP_EXTRACT || op_q == OP_PEEK) ? AW'(1) : pos_q;
			C_CHECK: addr = occ_q;
			C_RD_LAST: addr = occ_q;
			C_PLACE: begin
				we = 1'b1;
				addr = i_q;
			end
			C_UP_RD: addr = parent_i;
			C_UP_CMP: begin
				we = 1'b1;
				if (i_q > 1 && beats(order_min_q, cur_v_q, rd_v)) begin
					addr = i_q;
					wdata = {rd_v, rd_t};
				end else begin
					addr = i_q;
				end
			end
			C_DN_RD_L: addr = left_i;
			C_DN_RD_R: addr = right_i;
			C_DN_CMP: begin
				we = 1'b1;
				addr = i_q;
				if (dn_best_i != i_q) wdata = {dn_best_v, dn_best_t};
			end
			C_TOP_RD: addr = AW'(1);
			default: ;
		endcase
	end

	always_comb begin
		stat = '0;
		stat.out_busy = out_v_q && !rsp_ready;
		stat.up_more = i_q > 1 && beats(order_min_q, cur_v_q, rd_v);
		stat.dn_more = dn_best_i != i_q;
		stat.has_right = right_ok;
		stat.retry_down = op_q == OP_DELETE && i_q == pos_q;
		unique case (op_q)
			OP_INSERT: begin
				stat.done_early = {1'b0, occ_q} >= lim_eff;
				stat.go_up = 1'b1;
			end
			OP_EXTRACT: begin
				stat.done_early = occ_q == 0;
				stat.need_last = 1'b1;
				stat.go_down = 1'b1;
			end
			OP_PEEK: begin
				stat.done_early = occ_q == 0;
				stat.go_top = 1'b1;
			end
			OP_RAISE, OP_LOWER: begin
				stat.done_early = pos_q == 0 || pos_q > occ_q ||
					((op_q == OP_RAISE) ? (nv_q < rd_v) : (nv_q > rd_v));
				stat.go_up = dir_up_q;
				stat.go_down = !dir_up_q;
			end
			OP_DELETE: begin
				stat.done_early = pos_q == 0 || pos_q > occ_q;
				stat.need_last = 1'b1;
				stat.go_up = dir_up_q;
				stat.go_down = !dir_up_q;
			end
			default: stat.done_early = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_min_q <= 1'b0;
			limit_q <= CW'(1024);
			occ_q <= '0;
			ctr_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_ORDER) order_min_q <= cfg_data[0];
				else limit_q <= cfg_data;
			end
			if (cmd == C_EMIT) out_v_q <= 1'b1;
			else if (rsp_valid && rsp_ready) out_v_q <= 1'b0;
			unique case (cmd)
				C_CHECK: begin
					if (op_q == OP_INSERT && !stat.done_early) begin
						ctr_q <= ctr_q + 1'b1;
						occ_q <= occ_q + 1'b1;
					end
				end
				C_RD_LAST: if (op_q != OP_DELETE || !stat.done_early) occ_q <= occ_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			C_LOAD: begin
				op_q <= in_op;
				pos_q <= AW'(in_pos);
				nv_q <= in_val;
				res_v_q <= '0;
				res_t_q <= '0;
				res_st_q <= ST_OK;
				dir_up_q <= 1'b0;
			end
			C_CHECK: begin
				// results and special cases for the operation
				unique case (op_q)
					OP_INSERT: begin
						if (stat.done_early) begin
							res_st_q <= ST_FULL;
						end else begin
							i_q <= occ_q + 1'b1;
							cur_v_q <= nv_q;
							cur_t_q <= ctr_q + 1'b1;
							res_v_q <= nv_q;
							res_t_q <= ctr_q + 1'b1;
						end
					end
					OP_EXTRACT, OP_PEEK: begin
						if (stat.done_early) begin
							res_st_q <= ST_EMPTY;
						end else begin
							i_q <= AW'(1);
							res_v_q <= rd_v;
							res_t_q <= rd_t;
						end
					end
					OP_RAISE, OP_LOWER: begin
						if (pos_q == 0 || pos_q > occ_q) begin
							res_st_q <= ST_BAD_POS;
						end else if ((op_q == OP_RAISE && nv_q < rd_v) ||
								(op_q == OP_LOWER && nv_q > rd_v)) begin
							res_st_q <= ST_WRONG_DIR;
						end else begin
							i_q <= pos_q;
							cur_v_q <= nv_q;
							cur_t_q <= rd_t;
							dir_up_q <= (op_q == OP_RAISE) ? !order_min_q : order_min_q;
						end
					end
					OP_DELETE: begin
						if (stat.done_early) begin
							res_st_q <= ST_BAD_POS;
						end else begin
							i_q <= pos_q;
							res_v_q <= rd_v;
							res_t_q <= rd_t;
						end
					end
					default: ;
				endcase
			end
			C_TOP_CAP: begin
				if (op_q == OP_RAISE || op_q == OP_LOWER) begin
					res_v_q <= rd_v;
					res_t_q <= rd_t;
				end
			end
			C_RD_LAST: begin
				// moved entry: last slot, placed at i_q
				cur_v_q <= rd_v;
				cur_t_q <= rd_t;
			end
			C_PLACE: begin
				if (op_q == OP_DELETE) begin
					dir_up_q <= i_q > 1 && i_q <= occ_q;
				end
			end
			C_UP_CMP: begin
				if (stat.up_more) i_q <= parent_i;
			end
			C_DN_RD_L: begin
				best_q <= i_q;
				bv_q <= cur_v_q;
				bt_q <= cur_t_q;
			end
			C_DN_RD_R: begin
				if ({1'b0, left_i} <= {1'b0, occ_q} && i_q < AW'(2 ** (AW - 1)) &&
						beats(order_min_q, rd_v, bv_q)) begin
					best_q <= left_i;
					bv_q <= rd_v;
					bt_q <= rd_t;
				end
			end
			C_DN_CMP: begin
				if (dn_best_i != i_q) i_q <= dn_best_i;
			end
			default: ;
		endcase
		if (cmd == C_EMIT) begin
			out_val_q <= res_v_q;
			out_tag_q <= res_t_q;
			out_st_q <= res_st_q;
			out_cnt_q <= CW'(occ_q);
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp_value = out_val_q;
	assign rsp_tag = out_tag_q;
	assign rsp_status = out_st_q;
	assign rsp_count = out_cnt_q;
endmodule

/* hdl/bhpq_ctrl.sv */
// ----------------------------------------------------------------------------
// bhpq_ctrl: operation sequencer
// Steps each operation through check, move and sift phases where it needs them, and a result phase.
// ----------------------------------------------------------------------------
module bhpq_ctrl import bhpq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q;
	state_t state_d;
	logic   dn_stage_q;
	logic   dn_stage_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dn_stage_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dn_stage_q <= dn_stage_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dn_stage_d = dn_stage_q;
		cmd = C_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd = C_LOAD;
					state_d = S_RD_POS;
				end
			end
			S_RD_POS: begin
				cmd = C_RD_POS;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd = C_CHECK;
				if (stat.done_early) state_d = S_DONE;
				else if (stat.need_last) state_d = S_RD_LAST;
				else if (stat.go_top) state_d = S_TOP_RD;
				else state_d = S_PLACE;
			end
			S_RD_LAST: begin
				cmd = C_RD_LAST;
				state_d = S_PLACE;
			end
			S_PLACE: begin
				cmd = C_PLACE;
				dn_stage_d = 1'b0;
				state_d = S_TOP_RD;
			end
			S_TOP_RD: begin
				cmd = C_TOP_RD;
				state_d = S_TOP_CAP;
			end
			S_TOP_CAP: begin
				cmd = C_TOP_CAP;
				priority if (dn_stage_q || stat.go_top) state_d = S_DONE;
				else if (stat.go_up) state_d = S_UP_RD;
				else state_d = S_DN_RD_L;
			end
			S_UP_RD: begin
				cmd = C_UP_RD;
				state_d = S_UP_CMP;
			end
			S_UP_CMP: begin
				cmd = C_UP_CMP;
				if (stat.up_more) state_d = S_UP_RD;
				else if (stat.retry_down) state_d = S_DN_RD_L;
				else begin
					dn_stage_d = 1'b1;
					state_d = S_TOP_RD;
				end
			end
			S_DN_RD_L: begin
				cmd = C_DN_RD_L;
				state_d = S_DN_RD_R;
			end
			S_DN_RD_R: begin
				cmd = C_DN_RD_R;
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				cmd = C_DN_CMP;
				if (stat.dn_more) state_d = S_DN_RD_L;
				else begin
					dn_stage_d = 1'b1;
					state_d = S_TOP_RD;
				end
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd = C_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
